@@ src/u8dfa_pkg.sv @@
package u8dfa_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned ContW  = 6;

  typedef enum logic [3:0] {
    DS_ACCEPT = 4'd0,
    DS_REJECT = 4'd1,
    DS_TAIL1  = 4'd2,
    DS_TAIL2  = 4'd3,
    DS_E0     = 4'd4,
    DS_ED     = 4'd5,
    DS_F0     = 4'd6,
    DS_F13    = 4'd7,
    DS_F4     = 4'd8
  } dfa_state_t;

  typedef enum logic [3:0] {
    CL_ASCII = 4'd0,
    CL_C80   = 4'd1,
    CL_LEAD2 = 4'd2,
    CL_LEAD3 = 4'd3,
    CL_ED    = 4'd4,
    CL_F4    = 4'd5,
    CL_F13   = 4'd6,
    CL_CA0   = 4'd7,
    CL_BAD   = 4'd8,
    CL_C90   = 4'd9,
    CL_E0    = 4'd10,
    CL_F0    = 4'd11
  } byte_class_t;

  typedef enum logic [1:0] {
    STAT_COMPLETE = 2'd0,
    STAT_PARTIAL  = 2'd1,
    STAT_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    dfa_state_t           state;
    logic [CpW-1:0]       acc;
    status_t              status;
    logic [CpW-1:0]       code_point;
  } step_res_t;

  function automatic byte_class_t classify(input logic [ByteW-1:0] b);
    byte_class_t c;
    if (b < 8'h80)       c = CL_ASCII;
    else if (b < 8'h90)  c = CL_C80;
    else if (b < 8'hA0)  c = CL_C90;
    else if (b < 8'hC0)  c = CL_CA0;
    else if (b < 8'hC2)  c = CL_BAD;
    else if (b < 8'hE0)  c = CL_LEAD2;
    else if (b == 8'hE0) c = CL_E0;
    else if (b == 8'hED) c = CL_ED;
    else if (b < 8'hF0)  c = CL_LEAD3;
    else if (b == 8'hF0) c = CL_F0;
    else if (b < 8'hF4)  c = CL_F13;
    else if (b == 8'hF4) c = CL_F4;
    else                 c = CL_BAD;
    return c;
  endfunction

  function automatic dfa_state_t next_state(input dfa_state_t s, input byte_class_t c);
    dfa_state_t n;
    logic       cont_any;
    cont_any = (c == CL_C80) || (c == CL_C90) || (c == CL_CA0);
    n = DS_REJECT;
    case (s)
      DS_ACCEPT: begin
        case (c)
          CL_ASCII: n = DS_ACCEPT;
          CL_LEAD2: n = DS_TAIL1;
          CL_LEAD3: n = DS_TAIL2;
          CL_ED:    n = DS_ED;
          CL_F4:    n = DS_F4;
          CL_F13:   n = DS_F13;
          CL_E0:    n = DS_E0;
          CL_F0:    n = DS_F0;
          default:  n = DS_REJECT;
        endcase
      end
      DS_TAIL1: if (cont_any) n = DS_ACCEPT;
      DS_TAIL2: if (cont_any) n = DS_TAIL1;
      DS_E0:    if (c == CL_CA0) n = DS_TAIL1;
      DS_ED:    if (c == CL_C80 || c == CL_C90) n = DS_TAIL1;
      DS_F0:    if (c == CL_CA0 || c == CL_C90) n = DS_TAIL2;
      DS_F13:   if (cont_any) n = DS_TAIL2;
      DS_F4:    if (c == CL_C80) n = DS_TAIL2;
      default:  n = DS_REJECT;
    endcase
    return n;
  endfunction

endpackage

@@ src/u8dfa_step.sv @@
module u8dfa_step (
  input  logic [u8dfa_pkg::ByteW-1:0] data_byte,
  input  logic                        start_of_text,
  input  u8dfa_pkg::dfa_state_t       state,
  input  logic [u8dfa_pkg::CpW-1:0]   acc,
  output u8dfa_pkg::step_res_t        res
);

  u8dfa_pkg::dfa_state_t  cur;
  u8dfa_pkg::byte_class_t cls;
  u8dfa_pkg::dfa_state_t  nxt;
  logic [u8dfa_pkg::ByteW-1:0] lead_mask;
  logic [u8dfa_pkg::CpW-1:0]   acc_nxt;

  always_comb begin
    cur = start_of_text ? u8dfa_pkg::DS_ACCEPT : state;
    cls = u8dfa_pkg::classify(data_byte);
    nxt = u8dfa_pkg::next_state(cur, cls);
    lead_mask = 8'hFF >> cls;
    if (cur == u8dfa_pkg::DS_ACCEPT) begin
      acc_nxt = {{(u8dfa_pkg::CpW-u8dfa_pkg::ByteW){1'b0}}, data_byte & lead_mask};
    end else begin
      acc_nxt = {acc[u8dfa_pkg::CpW-u8dfa_pkg::ContW-1:0],
                 data_byte[u8dfa_pkg::ContW-1:0]};
    end
    res.state = nxt;
    res.acc   = acc_nxt;
    case (nxt)
      u8dfa_pkg::DS_ACCEPT: res.status = u8dfa_pkg::STAT_COMPLETE;
      u8dfa_pkg::DS_REJECT: res.status = u8dfa_pkg::STAT_REJECTED;
      default:              res.status = u8dfa_pkg::STAT_PARTIAL;
    endcase
    res.code_point = (nxt == u8dfa_pkg::DS_REJECT) ? '0 : acc_nxt;
  end

endmodule

@@ src/utf8_dfa_decoder.sv @@
// UTF-8 validating decoder, one byte per beat.
// Input channel: in_data_byte and in_start_of_text under in_valid/in_stall.
// Raise in_start_of_text on the first byte of a new text to return the
// automaton to accept before that byte is decoded.
// Result channel: out_status (0 complete, 1 inside a sequence, 2 rejected)
// and out_code_point under out_valid/out_stall. One result per input byte.
// out_code_point is the full scalar value when status is 0, the partial
// value inside a sequence, and zero once rejected. Reject is sticky until
// the next start of text.
// The result of an accepted byte is in the output register in the cycle after it is taken.
// Throughput: one byte per cycle while in_stall is low; the class lookup, transition and shift
// all sit between the state registers and the output register.
// Reset: automaton to accept, accumulator cleared, output register empty.
// Stall: the output register holds its beat; in_stall rises while a beat
// waits under out_stall, and falls in the cycle the beat is taken.
module utf8_dfa_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [u8dfa_pkg::ByteW-1:0] in_data_byte,
  input  logic                      in_start_of_text,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [u8dfa_pkg::CpW-1:0] out_code_point
);

  u8dfa_pkg::dfa_state_t     state_r;
  logic [u8dfa_pkg::CpW-1:0] acc_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  u8dfa_pkg::status_t        status_r;
  logic [u8dfa_pkg::CpW-1:0] code_point_r;
  u8dfa_pkg::step_res_t      res;
  logic                      in_take;

  u8dfa_step u_step (
    .data_byte     (in_data_byte),
    .start_of_text (in_start_of_text),
    .state         (state_r),
    .acc           (acc_r),
    .res           (res)
  );

  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= u8dfa_pkg::DS_ACCEPT;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        state_r <= res.state;
        acc_r   <= res.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      status_r     <= res.status;
      code_point_r <= res.code_point;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_code_point = code_point_r;

endmodule

@@ src/u8dfa_checker.sv @@
module u8dfa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [u8dfa_pkg::ByteW-1:0] in_data_byte,
  input logic                      in_start_of_text,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_status,
  input logic [u8dfa_pkg::CpW-1:0] out_code_point
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_code_point))
    else $error("result beat changed under stall");

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == u8dfa_pkg::STAT_REJECTED |-> out_code_point == '0)
    else $error("rejected beat shows a code point");

  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == u8dfa_pkg::STAT_COMPLETE |-> out_code_point <= 21'h10FFFF)
    else $error("complete code point out of range");

  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_start_of_text && !in_data_byte[7] |=>
      out_valid && out_status == u8dfa_pkg::STAT_COMPLETE &&
      out_code_point == {13'd0, $past(in_data_byte)})
    else $error("ascii byte after start of text not passed through");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_status == u8dfa_pkg::STAT_REJECTED &&
      in_valid && !in_stall && !in_start_of_text |=>
      out_valid && out_status == u8dfa_pkg::STAT_REJECTED)
    else $error("reject left without start of text");

endmodule

bind utf8_dfa_decoder u8dfa_checker u_u8dfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_data_byte     (in_data_byte),
  .in_start_of_text (in_start_of_text),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_code_point   (out_code_point)
);

@@ dv/u8dfa_decode_checker.sv @@
module u8dfa_decode_checker
  import u8dfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_start_of_text,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_status,
  input  logic [CpW-1:0]   out_code_point,
  output int               mismatches,
  output int               waiting,
  output int               n_complete,
  output int               n_partial,
  output int               n_rejected
);

  typedef struct packed {
    status_t        status;
    logic [CpW-1:0] cp;
  } char_result_t;

  char_result_t   expected_chars[$];
  dfa_state_t     auto_state;
  logic [CpW-1:0] cp_acc;
  int             n_results;

  function automatic byte_class_t class_of_byte(input logic [ByteW-1:0] b);
    if (b >= 8'hF5) return CL_BAD;
    if (b == 8'hF4) return CL_F4;
    if (b >= 8'hF1) return CL_F13;
    if (b == 8'hF0) return CL_F0;
    if (b == 8'hED) return CL_ED;
    if (b >= 8'hE1) return CL_LEAD3;
    if (b == 8'hE0) return CL_E0;
    if (b >= 8'hC2) return CL_LEAD2;
    if (b >= 8'hC0) return CL_BAD;
    if (b >= 8'hA0) return CL_CA0;
    if (b >= 8'h90) return CL_C90;
    if (b >= 8'h80) return CL_C80;
    return CL_ASCII;
  endfunction

  function automatic dfa_state_t step_automaton(input dfa_state_t s, input byte_class_t c);
    logic [11:0] any_cont;
    logic [11:0] takes;
    dfa_state_t  to;
    any_cont = '0;
    any_cont[CL_C80] = 1'b1;
    any_cont[CL_C90] = 1'b1;
    any_cont[CL_CA0] = 1'b1;
    takes = '0;
    to = DS_REJECT;
    case (s)
      DS_ACCEPT: begin
        case (c)
          CL_ASCII: return DS_ACCEPT;
          CL_LEAD2: return DS_TAIL1;
          CL_LEAD3: return DS_TAIL2;
          CL_E0:    return DS_E0;
          CL_ED:    return DS_ED;
          CL_F0:    return DS_F0;
          CL_F13:   return DS_F13;
          CL_F4:    return DS_F4;
          default:  return DS_REJECT;
        endcase
      end
      DS_TAIL1: begin
        takes = any_cont;
        to = DS_ACCEPT;
      end
      DS_TAIL2: begin
        takes = any_cont;
        to = DS_TAIL1;
      end
      DS_E0: begin
        takes[CL_CA0] = 1'b1;
        to = DS_TAIL1;
      end
      DS_ED: begin
        takes[CL_C80] = 1'b1;
        takes[CL_C90] = 1'b1;
        to = DS_TAIL1;
      end
      DS_F0: begin
        takes[CL_C90] = 1'b1;
        takes[CL_CA0] = 1'b1;
        to = DS_TAIL2;
      end
      DS_F13: begin
        takes = any_cont;
        to = DS_TAIL2;
      end
      DS_F4: begin
        takes[CL_C80] = 1'b1;
        to = DS_TAIL2;
      end
      default: takes = '0;
    endcase
    return takes[c] ? to : DS_REJECT;
  endfunction

  always @(posedge clk) begin
    char_result_t want;
    byte_class_t  c;
    if (!rst_n) begin
      auto_state = DS_ACCEPT;
      cp_acc = '0;
      expected_chars.delete();
      mismatches = 0;
      n_complete = 0;
      n_partial = 0;
      n_rejected = 0;
      n_results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: unexpected result, status %0d code point %h",
                     n_results, out_status, out_code_point);
        end else begin
          want = expected_chars.pop_front();
          if (out_status !== want.status || out_code_point !== want.cp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected status %0d cp %h, got status %0d cp %h",
                       n_results, want.status, want.cp, out_status, out_code_point);
          end
          case (want.status)
            STAT_COMPLETE: n_complete++;
            STAT_PARTIAL:  n_partial++;
            default:       n_rejected++;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        if (in_start_of_text)
          auto_state = DS_ACCEPT;
        c = class_of_byte(in_data_byte);
        if (auto_state == DS_ACCEPT)
          cp_acc = CpW'(in_data_byte & (8'hFF >> c));
        else
          cp_acc = {cp_acc[CpW-ContW-1:0], in_data_byte[ContW-1:0]};
        auto_state = step_automaton(auto_state, c);
        if (auto_state == DS_ACCEPT)
          want.status = STAT_COMPLETE;
        else if (auto_state == DS_REJECT)
          want.status = STAT_REJECTED;
        else
          want.status = STAT_PARTIAL;
        want.cp = (want.status == STAT_REJECTED) ? '0 : cp_acc;
        expected_chars.push_back(want);
      end
    end
    waiting = expected_chars.size();
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import u8dfa_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [ByteW-1:0] in_data_byte;
  logic             in_start_of_text;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;
  logic [CpW-1:0]   out_code_point;

  int mismatches;
  int waiting;
  int n_complete;
  int n_partial;
  int n_rejected;
  int bytes_sent;
  int rx_hold;
  int squeeze_left;
  bit tx_burst;
  bit rx_burst;
  bit squeeze_req;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  utf8_dfa_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_text (in_start_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_code_point   (out_code_point)
  );

  u8dfa_decode_checker i_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_text (in_start_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_code_point   (out_code_point),
    .mismatches       (mismatches),
    .waiting          (waiting),
    .n_complete       (n_complete),
    .n_partial        (n_partial),
    .n_rejected       (n_rejected)
  );

  // receiver: hold after each taken beat, or for a long squeeze on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      rx_hold = rx_burst ? 0 : $urandom_range(0, 19);
  end

  always @(negedge clk) begin
    if (squeeze_req) begin
      squeeze_req = 1'b0;
      squeeze_left = 200;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      out_stall <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b, input logic sot);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_of_text <= sot;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_seq(input logic [3:0][7:0] seq, input int n, input logic sot);
    for (int k = 0; k < n; k++)
      push_byte(seq[k], sot && (k == 0));
  endtask

  function automatic logic [20:0] random_scalar(input int min_len);
    logic [20:0] cp;
    case ($urandom_range(min_len - 1, 3))
      0: cp = 21'($urandom_range(0, 'h7F));
      1: cp = 21'($urandom_range('h80, 'h7FF));
      2: begin
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= 21'hD800)
          cp = cp + 21'h800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] seq);
    seq = '0;
    if (cp < 'h80) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 'h10000) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      return 3;
    end
    seq[0] = {5'b11110, cp[20:18]};
    seq[1] = {2'b10, cp[17:12]};
    seq[2] = {2'b10, cp[11:6]};
    seq[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  initial begin
    static logic [8:0] opening [24] = '{
      9'h100, 9'h07F,
      9'h0C2, 9'h080,
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
      9'h0E0, 9'h0A0, 9'h080,
      9'h0EF, 9'h141,
      9'h0FF, 9'h080,
      9'h1C1,
      9'h1E0, 9'h080,
      9'h1ED, 9'h0A0,
      9'h1F0, 9'h090, 9'h080, 9'h080
    };
    logic [3:0][7:0] seq;
    int              len;
    int              kind;
    bit              restart;
    bit              squeezed;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_start_of_text = 1'b0;
    out_stall = 1'b0;
    rx_hold = 0;
    squeeze_left = 0;
    squeeze_req = 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    bytes_sent = 0;
    restart = 1'b1;
    squeezed = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening[k])
      push_byte(opening[k][7:0], opening[k][8]);

    while (bytes_sent < 1050) begin
      if ($urandom_range(0, 63) == 0)
        tx_burst = ~tx_burst;
      if ($urandom_range(0, 63) == 0)
        rx_burst = ~rx_burst;
      if (!squeezed && bytes_sent >= 400) begin
        squeeze_req = 1'b1;
        squeezed = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        len = utf8_encode(random_scalar(1), seq);
        push_seq(seq, len, restart || ($urandom_range(0, 19) == 0));
        restart = 1'b0;
      end else if (kind < 88) begin
        // truncate a multibyte sequence
        len = utf8_encode(random_scalar(2), seq);
        push_seq(seq, $urandom_range(1, len - 1), restart);
        restart = 1'b1;
      end else if (kind < 95) begin
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        restart = 1'b1;
      end else begin
        // corrupt one trailing byte
        len = utf8_encode(random_scalar(2), seq);
        seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        push_seq(seq, len, restart);
        restart = 1'b1;
      end
    end

    in_valid <= 1'b0;
    wait (waiting == 0);
    repeat (4) @(negedge clk);
    $display("sent %0d bytes: 24 directed, the rest random characters, noise and broken sequences",
             bytes_sent);
    $display("results checked: %0d complete, %0d partial, %0d rejected, %0d mismatches",
             n_complete, n_partial, n_rejected, mismatches);
    if (mismatches == 0 && waiting == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
